### design/lsdt_pkg.sv
// Shared constants, types and helpers of the label shard directory table.
package lsdt_pkg;

  localparam int unsigned TableEntries = 256;
  localparam int unsigned IdxW         = 8;
  localparam int unsigned MaxShards    = 64;
  localparam int unsigned CountBits    = 32;

  localparam logic [2:0] CMD_LOCAL_ADD  = 3'd0;
  localparam logic [2:0] CMD_LOCAL_REM  = 3'd1;
  localparam logic [2:0] CMD_REMOTE_ADD = 3'd2;
  localparam logic [2:0] CMD_REMOTE_REM = 3'd3;
  localparam logic [2:0] CMD_QUERY      = 3'd4;

  localparam logic [2:0] REG_DIR_EN    = 3'd0;
  localparam logic [2:0] REG_PRUNE_EN  = 3'd1;
  localparam logic [2:0] REG_SHARD_CNT = 3'd2;
  localparam logic [2:0] REG_LOCAL_IDX = 3'd3;
  localparam logic [2:0] REG_LOCAL_VAL = 3'd4;
  localparam logic [2:0] REG_CLUS_SIG  = 3'd5;

  typedef struct packed {
    logic                 used;
    logic [63:0]          key;
    logic [CountBits-1:0] count;
    logic                 has_bits;
    logic [63:0]          bits;
  } entry_t;

  typedef struct packed {
    logic        update_valid;
    logic        update_is_add;
    logic        needs_refresh;
    logic        table_full;
    logic        query_done;
    logic        query_known;
    logic [63:0] target_bits;
    logic        local_included;
  } result_t;

  // Folds the key into a starting slot for the probe.
  function automatic logic [IdxW-1:0] home_slot(input logic [63:0] key);
    logic [IdxW-1:0] h;
    h = '0;
    for (int i = 0; i < 64 / IdxW; i++) begin
      h = h ^ key[i*IdxW +: IdxW];
    end
    return h;
  endfunction

endpackage

### design/label_shard_directory_table.sv
// Label shard directory table: hashed entry memory with probe and read-modify-write.
// A probe reads one entry at a time from the folded key slot and stops at a key match or a
// never-written slot (at most 256 probes). A new item is accepted only when idle, after the
// prior result has entered the output register; a result waiting there holds off the next item.
// Reset clears control state and the per-entry written bits; no clearing pass is needed.
module label_shard_directory_table import lsdt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  cmd,
  input  logic [63:0] hash_key,
  input  logic [5:0]  shard_index,
  input  logic [63:0] message_signature,
  input  logic        term_exact,
  input  logic        last_term,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        update_valid,
  output logic        update_is_add,
  output logic        needs_refresh,
  output logic        table_full,
  output logic        query_done,
  output logic        query_known,
  output logic [63:0] target_bits,
  output logic        local_included,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_READ   = 3'd1;
  localparam logic [2:0] S_CHECK  = 3'd2;
  localparam logic [2:0] S_EXEC   = 3'd3;
  localparam logic [2:0] S_RESULT = 3'd4;

  logic        dir_en, prune_en, local_val;
  logic [6:0]  shard_cnt;
  logic [5:0]  local_idx;
  logic [63:0] clus_sig;

  logic [2:0]  state;
  logic [2:0]  cmd_r;
  logic [63:0] key_r;
  logic [5:0]  shard_r;
  logic        sig_ok_r, exact_r, last_r;
  logic [IdxW-1:0] probe, free_idx;
  logic [IdxW:0]   probes;
  logic        found, free_ok;
  logic [TableEntries-1:0] ever;
  logic [63:0] accum;
  logic        acc_ok;
  result_t     res;

  entry_t mem [TableEntries];
  entry_t rd_data, wr_data;
  logic   wr_en;
  logic [IdxW-1:0] wr_idx;

  logic [6:0]  cnt_cap;
  logic        local_known;
  logic [63:0] local_bit;
  assign cnt_cap     = (shard_cnt > 7'(MaxShards)) ? 7'(MaxShards) : shard_cnt;
  assign local_known = local_val && (cnt_cap != 7'd0) && ({1'b0, local_idx} < cnt_cap);
  assign local_bit   = 64'd1 << local_idx;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    rd_data <= mem[probe];
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
  end

  // Read-modify-write of the entry picked by the probe.
  logic [CountBits-1:0] cnt0, cnt1;
  logic        hb1;
  logic [63:0] bits1;
  logic        have_e, used1;
  result_t     res_n;
  logic [63:0] accum_n;
  logic        ok_n;

  always_comb begin
    cnt0   = found ? rd_data.count : '0;
    cnt1   = cnt0;
    hb1    = found ? rd_data.has_bits : 1'b0;
    bits1  = (found && rd_data.has_bits) ? rd_data.bits : 64'd0;
    have_e = found || free_ok;
    used1  = 1'b1;
    wr_en  = 1'b0;
    wr_idx = found ? probe : free_idx;
    res_n  = '0;
    accum_n = accum;
    ok_n    = acc_ok;
    if (state == S_EXEC) begin
      case (cmd_r)
        CMD_QUERY: begin
          if (!dir_en || !prune_en || !local_known || !exact_r || !found ||
              !rd_data.has_bits) begin
            ok_n = 1'b0;
          end else begin
            accum_n = accum & rd_data.bits;
          end
          if (last_r) begin
            res_n.query_done = 1'b1;
            if (ok_n) begin
              res_n.query_known    = 1'b1;
              res_n.target_bits    = accum_n;
              res_n.local_included = accum_n[local_idx];
            end
            accum_n = '1;
            ok_n    = 1'b1;
          end
        end
        CMD_LOCAL_ADD: begin
          if (dir_en) begin
            if (!have_e) begin
              res_n.table_full = 1'b1;
            end else begin
              wr_en = 1'b1;
              if (cnt0 != '1) begin
                cnt1 = cnt0 + 1'b1;
                if (cnt0 == '0 && local_known) begin
                  hb1 = 1'b1;
                  bits1 = bits1 | local_bit;
                  res_n.update_valid  = 1'b1;
                  res_n.update_is_add = 1'b1;
                end
              end
            end
          end
        end
        CMD_LOCAL_REM: begin
          if (dir_en && found && cnt0 != '0) begin
            wr_en = 1'b1;
            cnt1 = cnt0 - 1'b1;
            if (cnt0 == CountBits'(1) && local_known) begin
              hb1 = 1'b1;
              bits1 = bits1 & ~local_bit;
              res_n.update_valid = 1'b1;
            end
            if (cnt1 == '0 && !hb1) begin
              used1 = 1'b0;
            end
          end
        end
        CMD_REMOTE_ADD, CMD_REMOTE_REM: begin
          if (dir_en) begin
            if (!sig_ok_r) begin
              res_n.needs_refresh = 1'b1;
            end else if (!have_e) begin
              res_n.table_full = 1'b1;
            end else begin
              wr_en = 1'b1;
              hb1 = 1'b1;
              if (cmd_r == CMD_REMOTE_ADD) begin
                bits1 = bits1 | (64'd1 << shard_r);
              end else begin
                bits1 = bits1 & ~(64'd1 << shard_r);
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
    wr_data.used     = used1;
    wr_data.key      = key_r;
    wr_data.count    = cnt1;
    wr_data.has_bits = hb1;
    wr_data.bits     = bits1;
  end

  // A slot that was never written holds no entry, whatever the memory returns.
  logic key_hit, slot_free, probe_end;
  assign key_hit   = ever[probe] && rd_data.used && (rd_data.key == key_r);
  assign slot_free = !ever[probe] || !rd_data.used;
  assign probe_end = !ever[probe] || (probes == (IdxW+1)'(TableEntries - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ever <= '0;
      accum <= '1;
      acc_ok <= 1'b1;
      out_valid <= 1'b0;
      dir_en <= 1'b0;
      prune_en <= 1'b0;
      shard_cnt <= '0;
      local_idx <= '0;
      local_val <= 1'b0;
      clus_sig <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_DIR_EN:    dir_en <= cfg_data[0];
          REG_PRUNE_EN:  prune_en <= cfg_data[0];
          REG_SHARD_CNT: shard_cnt <= cfg_data[6:0];
          REG_LOCAL_IDX: local_idx <= cfg_data[5:0];
          REG_LOCAL_VAL: local_val <= cfg_data[0];
          REG_CLUS_SIG:  clus_sig <= cfg_data;
          default: begin
          end
        endcase
      end
      if (out_valid && out_ready && state != S_RESULT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd_r    <= cmd;
            key_r    <= hash_key;
            shard_r  <= shard_index;
            exact_r  <= term_exact;
            last_r   <= last_term;
            sig_ok_r <= (message_signature == clus_sig) && ({1'b0, shard_index} < cnt_cap);
            probe    <= home_slot(hash_key);
            probes   <= '0;
            found    <= 1'b0;
            free_ok  <= 1'b0;
            // Items that cannot touch the table skip the lookup.
            if (cmd > CMD_QUERY || (!dir_en && cmd != CMD_QUERY)) begin
              state <= S_EXEC;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_READ: state <= S_CHECK;
        S_CHECK: begin
          if (key_hit) begin
            found <= 1'b1;
            state <= S_EXEC;
          end else begin
            if (slot_free && !free_ok) begin
              free_ok  <= 1'b1;
              free_idx <= probe;
            end
            if (probe_end) begin
              state <= S_EXEC;
            end else begin
              probe  <= probe + 1'b1;
              probes <= probes + 1'b1;
              state  <= S_READ;
            end
          end
        end
        S_EXEC: begin
          // A query never claims a slot.
          if (wr_en) begin
            ever[wr_idx] <= 1'b1;
          end
          accum  <= accum_n;
          acc_ok <= ok_n;
          res    <= res_n;
          state  <= S_RESULT;
        end
        S_RESULT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_RESULT && (!out_valid || out_ready)) begin
      update_valid   <= res.update_valid;
      update_is_add  <= res.update_is_add;
      needs_refresh  <= res.needs_refresh;
      table_full     <= res.table_full;
      query_done     <= res.query_done;
      query_known    <= res.query_known;
      target_bits    <= res.target_bits;
      local_included <= res.local_included;
    end
  end

  a_known_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && query_known |-> query_done) else $error("known without done");
  a_target_known: assert property (@(posedge clk) disable iff (rst)
    out_valid && target_bits != 64'd0 |-> query_known) else $error("target while unknown");
  a_one_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $countones({update_valid, needs_refresh, table_full, query_done}) <= 1)
    else $error("conflicting result flags");
  a_exec_once: assert property (@(posedge clk) disable iff (rst)
    state == S_EXEC |=> state == S_RESULT) else $error("exec not followed by result");
  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == S_READ || state == S_EXEC)
    else $error("accept did not start work");

endmodule
